// ----- hw/rtl/tbfp_pkg.sv -----
package tbfp_pkg;

  // Slot bookkeeping
  localparam int SLOTS         = 3;
  localparam int DEF_FRAME_LEN = 25;

  typedef logic [1:0] slot_t;

  localparam slot_t SLOT_CUR_RST = 2'd0;
  localparam slot_t SLOT_NXT_RST = 2'd1;
  localparam slot_t SLOT_SPR_RST = 2'd2;

  // Command kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // APB register map, one 32-bit register every 4 bytes
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_HEADER       = 2'd0,
    REG_FOOTER_MASK  = 2'd1,
    REG_FOOTER_VALUE = 2'd2
  } reg_idx_t;

  localparam logic [7:0] HEADER_RST       = 8'd15;
  localparam logic [7:0] FOOTER_MASK_RST  = 8'd255;
  localparam logic [7:0] FOOTER_VALUE_RST = 8'd0;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] footer_mask;
    logic [7:0] footer_value;
  } cfg_t;

  // Channel words
  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  tx_byte;
    logic        empty_res;
    logic [31:0] rx_byte_count;
    logic [31:0] tx_byte_count;
    logic [31:0] rx_frame_count;
    logic [31:0] tx_frame_count;
    logic [31:0] superseded_count;
    logic [31:0] sync_error_count;
  } out_word_t;

endpackage

// ----- hw/rtl/tbfp_chan_if.sv -----
// Command channel: push or pop requests
interface tbfp_cmd_if;
  logic               valid;
  logic               ready;
  tbfp_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Response channel: one word per command
interface tbfp_rsp_if;
  logic                valid;
  logic                ready;
  tbfp_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/triple_buffered_frame_pipe_core.sv -----
// Triple-buffered frame pipe.
// cmd carries one word per request: kind 0 pushes rx_byte, kind 1 pops one
// byte of the current slot. rsp returns exactly one word per request, with
// the accept flag, the popped byte and a snapshot of all counters after
// the request. Both channels use valid/ready; a word moves when both are
// high. Header, footer mask and footer value sit on the APB port and are
// written only while no request is outstanding, a rule for the user that
// the block does not enforce. The response is valid the cycle after the
// request is taken; one request per cycle unless rsp stalls. The frame
// store is a single-port RAM with registered read; the pop read is issued
// in the accept cycle and the data lands in the response register at the
// same edge as the bookkeeping. When rsp is stalled, the response register
// holds and cmd.ready drops until the word is taken; cmd.ready is high
// whenever the register is empty or being drained in the same cycle.
// Reset (rst, synchronous) clears slot bookkeeping, roles, counters and the
// config registers. The frame store is not cleared; only written bytes are
// ever read back.
module triple_buffered_frame_pipe_core #(
  parameter int FRAME_LEN = tbfp_pkg::DEF_FRAME_LEN
) (
  input  logic                          clk,
  input  logic                          rst,
  tbfp_cmd_if.sink                      cmd,
  tbfp_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tbfp_pkg::PADDR_W-1:0]  paddr,
  input  logic [tbfp_pkg::PDATA_W-1:0]  pwdata,
  output logic [tbfp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import tbfp_pkg::*;

  localparam int LEN_W  = $clog2(FRAME_LEN + 1);
  localparam int DEPTH  = SLOTS * FRAME_LEN;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam len_t LEN_FULL = len_t'(FRAME_LEN);
  localparam len_t LEN_LAST = len_t'(FRAME_LEN - 1);
  localparam len_t LEN_ONE  = len_t'(1);
  localparam addr_t SLOT_SPAN = addr_t'(FRAME_LEN);

  // Config registers
  cfg_t cfg;

  tbfp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Slot bookkeeping
  len_t             slot_len [SLOTS];
  len_t             slot_len_next [SLOTS];
  len_t             slot_rd [SLOTS];
  len_t             slot_rd_next [SLOTS];
  logic [SLOTS-1:0] slot_cmp, slot_cmp_next;
  logic [SLOTS-1:0] slot_snd, slot_snd_next;
  slot_t            cur, cur_next;
  slot_t            nxt, nxt_next;
  slot_t            spr, spr_next;
  slot_t            col, col_next;
  logic             collecting, collecting_next;

  logic [31:0] rx_byte_cnt, rx_byte_cnt_next;
  logic [31:0] tx_byte_cnt, tx_byte_cnt_next;
  logic [31:0] rx_frame_cnt, rx_frame_cnt_next;
  logic [31:0] tx_frame_cnt, tx_frame_cnt_next;
  logic [31:0] supersedes, supersedes_next;
  logic [31:0] sync_errors, sync_errors_next;

  // Frame store port
  logic [7:0] frame_store [DEPTH];
  logic       mem_we, mem_re;
  addr_t      mem_addr;
  logic [7:0] rd_data;

  // Response register
  logic      out_valid;
  logic      acc, acc_next;
  logic      popped;
  logic      cmd_fire;
  out_word_t rsp_word;

  assign cmd.ready = !out_valid || rsp.ready;
  assign cmd_fire  = cmd.valid && cmd.ready;

  // Request decode and bookkeeping update
  always_comb begin
    slot_t      s;
    len_t       nlen;
    len_t       nrd;
    logic       owes_cur;
    logic [7:0] b;

    slot_len_next     = slot_len;
    slot_rd_next      = slot_rd;
    slot_cmp_next     = slot_cmp;
    slot_snd_next     = slot_snd;
    cur_next          = cur;
    nxt_next          = nxt;
    spr_next          = spr;
    col_next          = col;
    collecting_next   = collecting;
    rx_byte_cnt_next  = rx_byte_cnt;
    tx_byte_cnt_next  = tx_byte_cnt;
    rx_frame_cnt_next = rx_frame_cnt;
    tx_frame_cnt_next = tx_frame_cnt;
    supersedes_next   = supersedes;
    sync_errors_next  = sync_errors;
    mem_we            = 1'b0;
    mem_re            = 1'b0;
    mem_addr          = '0;
    acc_next          = 1'b0;

    b        = cmd.data.rx_byte;
    s        = col;
    nlen     = '0;
    nrd      = '0;
    owes_cur = slot_cmp[cur] || slot_snd[cur] || (slot_rd[cur] < slot_len[cur]);

    if (cmd_fire) begin
      if (cmd.data.kind == KIND_PUSH) begin
        if (collecting || (b == cfg.header_byte)) begin
          // pick a slot on the header byte
          if (!collecting) begin
            if (!owes_cur) begin
              s = cur;
            end else if (!slot_cmp[nxt]) begin
              s = nxt;
            end else begin
              s = spr;
            end
          end
          mem_we   = 1'b1;
          mem_addr = addr_t'(addr_t'(s) * SLOT_SPAN)
                   + addr_t'((slot_len[s] < LEN_FULL) ? slot_len[s] : LEN_LAST);
          nlen     = (slot_len[s] < LEN_FULL) ? slot_len[s] + LEN_ONE : slot_len[s];
          slot_len_next[s] = nlen;
          rx_byte_cnt_next = rx_byte_cnt + 32'd1;
          acc_next         = 1'b1;
          collecting_next  = 1'b1;
          col_next         = s;

          // frame end: footer check
          if (nlen == LEN_FULL) begin
            collecting_next = 1'b0;
            if ((b & cfg.footer_mask) == cfg.footer_value) begin
              slot_cmp_next[s]  = 1'b1;
              rx_frame_cnt_next = rx_frame_cnt + 32'd1;
              if (s == spr) begin
                if (slot_cmp[nxt]) begin
                  supersedes_next = supersedes + 32'd1;
                end
                nxt_next           = spr;
                spr_next           = nxt;
                slot_len_next[nxt] = '0;
                slot_rd_next[nxt]  = '0;
                slot_cmp_next[nxt] = 1'b0;
                slot_snd_next[nxt] = 1'b0;
              end
            end else begin
              sync_errors_next = sync_errors + 32'd1;
              if (s != cur) begin
                slot_len_next[s] = '0;
                slot_rd_next[s]  = '0;
                slot_cmp_next[s] = 1'b0;
                slot_snd_next[s] = 1'b0;
              end
            end
          end
        end
      end else begin
        // pop from the current slot
        if ((slot_rd[cur] < slot_len[cur]) && (slot_rd[cur] < LEN_FULL)) begin
          mem_re   = 1'b1;
          mem_addr = addr_t'(addr_t'(cur) * SLOT_SPAN) + addr_t'(slot_rd[cur]);
          acc_next = 1'b1;
          nrd      = slot_rd[cur] + LEN_ONE;
          slot_rd_next[cur]  = nrd;
          slot_snd_next[cur] = 1'b1;
          tx_byte_cnt_next   = tx_byte_cnt + 32'd1;

          // drained: promote next to current
          if (!(collecting && (col == cur)) && (nrd == slot_len[cur])) begin
            if (slot_cmp[cur]) begin
              tx_frame_cnt_next = tx_frame_cnt + 32'd1;
            end
            cur_next           = nxt;
            nxt_next           = cur;
            slot_len_next[cur] = '0;
            slot_rd_next[cur]  = '0;
            slot_cmp_next[cur] = 1'b0;
            slot_snd_next[cur] = 1'b0;
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_len[i] <= '0;
        slot_rd[i]  <= '0;
      end
      slot_cmp     <= '0;
      slot_snd     <= '0;
      cur          <= SLOT_CUR_RST;
      nxt          <= SLOT_NXT_RST;
      spr          <= SLOT_SPR_RST;
      col          <= SLOT_CUR_RST;
      collecting   <= 1'b0;
      rx_byte_cnt  <= '0;
      tx_byte_cnt  <= '0;
      rx_frame_cnt <= '0;
      tx_frame_cnt <= '0;
      supersedes   <= '0;
      sync_errors  <= '0;
    end else begin
      slot_len     <= slot_len_next;
      slot_rd      <= slot_rd_next;
      slot_cmp     <= slot_cmp_next;
      slot_snd     <= slot_snd_next;
      cur          <= cur_next;
      nxt          <= nxt_next;
      spr          <= spr_next;
      col          <= col_next;
      collecting   <= collecting_next;
      rx_byte_cnt  <= rx_byte_cnt_next;
      tx_byte_cnt  <= tx_byte_cnt_next;
      rx_frame_cnt <= rx_frame_cnt_next;
      tx_frame_cnt <= tx_frame_cnt_next;
      supersedes   <= supersedes_next;
      sync_errors  <= sync_errors_next;
    end
  end

  // Frame store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[mem_addr] <= cmd.data.rx_byte;
    end
    if (mem_re) begin
      rd_data <= frame_store[mem_addr];
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      acc    <= acc_next;
      popped <= acc_next && (cmd.data.kind == KIND_POP);
    end
  end

  // Counters are held in state; they only move when the next word is taken
  always_comb begin
    rsp_word.accepted         = acc;
    rsp_word.tx_byte          = popped ? rd_data : 8'd0;
    rsp_word.empty_res        = (slot_rd[cur] == slot_len[cur]);
    rsp_word.rx_byte_count    = rx_byte_cnt;
    rsp_word.tx_byte_count    = tx_byte_cnt;
    rsp_word.rx_frame_count   = rx_frame_cnt;
    rsp_word.tx_frame_count   = tx_frame_cnt;
    rsp_word.superseded_count = supersedes;
    rsp_word.sync_error_count = sync_errors;
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = rsp_word;

  // Checks

  // The three roles always name three different slots
  a_roles_distinct: assert property (@(posedge clk) disable iff (rst)
    (cur != nxt) && (cur != spr) && (nxt != spr))
    else $error("slot roles overlap");

  // A slot is never read past what it holds
  a_rd_le_len: assert property (@(posedge clk) disable iff (rst)
    (slot_rd[0] <= slot_len[0]) && (slot_rd[1] <= slot_len[1]) &&
    (slot_rd[2] <= slot_len[2]))
    else $error("read position beyond slot length");

  // One request moves at most one of the byte counters
  a_one_byte_counter: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> (rx_byte_cnt == $past(rx_byte_cnt)) ||
                 (tx_byte_cnt == $past(tx_byte_cnt)))
    else $error("push and pop counters moved together");

  // Every taken request yields a pending response word
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> out_valid)
    else $error("response missing after request");

endmodule

// ----- hw/rtl/tbfp_cfg.sv -----
module tbfp_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tbfp_pkg::PADDR_W-1:0]  paddr,
  input  logic [tbfp_pkg::PDATA_W-1:0]  pwdata,
  output logic [tbfp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output tbfp_pkg::cfg_t                cfg
);
  import tbfp_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte  <= HEADER_RST;
      cfg.footer_mask  <= FOOTER_MASK_RST;
      cfg.footer_value <= FOOTER_VALUE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_HEADER:       cfg.header_byte  <= pwdata[7:0];
        REG_FOOTER_MASK:  cfg.footer_mask  <= pwdata[7:0];
        REG_FOOTER_VALUE: cfg.footer_value <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    prdata = '0;
    case (idx)
      REG_HEADER:       prdata[7:0] = cfg.header_byte;
      REG_FOOTER_MASK:  prdata[7:0] = cfg.footer_mask;
      REG_FOOTER_VALUE: prdata[7:0] = cfg.footer_value;
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import tbfp_pkg::*;

  localparam int FL          = DEF_FRAME_LEN;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_COMB
  } stall_mode_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  tbfp_cmd_if cmd_ch ();
  tbfp_rsp_if rsp_ch ();

  triple_buffered_frame_pipe_core #(
    .FRAME_LEN(FL)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow copy of the pipe: slots, roles, counters and frame format
  cfg_t        fmt;
  logic [7:0]  bytes_mem [SLOTS*FL];
  logic [4:0]  fill_len [SLOTS];
  logic [4:0]  rd_pos [SLOTS];
  logic        is_done [SLOTS];
  logic        is_sending [SLOTS];
  slot_t       cur_s;
  slot_t       nxt_s;
  slot_t       spr_s;
  slot_t       fill_s;
  logic        in_frame;
  logic [31:0] n_rx_byte;
  logic [31:0] n_tx_byte;
  logic [31:0] n_rx_frame;
  logic [31:0] n_tx_frame;
  logic [31:0] n_superseded;
  logic [31:0] n_sync_err;

  out_word_t   status_due [$];
  out_word_t   due_w;
  int          fail_cnt   = 0;
  int          moved_cnt  = 0;
  int          cyc_cnt    = 0;
  int          burst_left = 0;
  bit          no_gaps    = 1'b0;

  // Receiver stall state
  stall_mode_t rcv_mode   = RX_OPEN;
  int          mode_left  = 0;
  int          hold_left  = 0;
  int          hold_asked = 0;
  int          hold_taken = 0;
  int          rcv_cyc    = 0;

  function automatic void wipe_slot(slot_t s);
    fill_len[s]   = '0;
    rd_pos[s]     = '0;
    is_done[s]    = 1'b0;
    is_sending[s] = 1'b0;
  endfunction

  function automatic void init_model();
    fmt.header_byte  = HEADER_RST;
    fmt.footer_mask  = FOOTER_MASK_RST;
    fmt.footer_value = FOOTER_VALUE_RST;
    for (int i = 0; i < SLOTS * FL; i++) bytes_mem[i] = '0;
    for (int i = 0; i < SLOTS; i++) wipe_slot(slot_t'(i));
    cur_s        = SLOT_CUR_RST;
    nxt_s        = SLOT_NXT_RST;
    spr_s        = SLOT_SPR_RST;
    fill_s       = SLOT_CUR_RST;
    in_frame     = 1'b0;
    n_rx_byte    = '0;
    n_tx_byte    = '0;
    n_rx_frame   = '0;
    n_tx_frame   = '0;
    n_superseded = '0;
    n_sync_err   = '0;
  endfunction

  // A slot owes something while complete, partly sent or holding unread bytes
  function automatic logic slot_busy(slot_t s);
    return is_done[s] || is_sending[s] || (rd_pos[s] < fill_len[s]);
  endfunction

  // Status word the pipe returns for one request, updating the shadow state
  function automatic out_word_t predict_status(in_word_t w);
    out_word_t o;
    slot_t     s;
    slot_t     t;
    slot_t     c;
    int        pos;
    logic      take;
    o = '0;
    if (w.kind == KIND_PUSH) begin
      take = 1'b1;
      if (!in_frame) begin
        if (w.rx_byte != fmt.header_byte) begin
          take = 1'b0;
        end else begin
          if (!slot_busy(cur_s)) fill_s = cur_s;
          else if (!is_done[nxt_s]) fill_s = nxt_s;
          else fill_s = spr_s;
          in_frame = 1'b1;
        end
      end
      if (take) begin
        s   = fill_s;
        pos = (fill_len[s] < FL) ? int'(fill_len[s]) : FL - 1;
        bytes_mem[int'(s) * FL + pos] = w.rx_byte;
        if (fill_len[s] < FL) fill_len[s] = fill_len[s] + 5'd1;
        n_rx_byte  = n_rx_byte + 1;
        o.accepted = 1'b1;
        if (fill_len[s] == FL) begin
          // frame ends here: footer decides complete or sync error
          if ((bytes_mem[int'(s) * FL + FL - 1] & fmt.footer_mask) == fmt.footer_value) begin
            is_done[s] = 1'b1;
            if (s == spr_s) begin
              if (is_done[nxt_s]) n_superseded = n_superseded + 1;
              t     = nxt_s;
              nxt_s = spr_s;
              spr_s = t;
              wipe_slot(spr_s);
            end
            n_rx_frame = n_rx_frame + 1;
          end else begin
            n_sync_err = n_sync_err + 1;
            if (s != cur_s) wipe_slot(s);
          end
          in_frame = 1'b0;
        end
      end
    end else begin
      c = cur_s;
      if (rd_pos[c] < fill_len[c] && rd_pos[c] < FL) begin
        o.accepted    = 1'b1;
        o.tx_byte     = bytes_mem[int'(c) * FL + int'(rd_pos[c])];
        rd_pos[c]     = rd_pos[c] + 5'd1;
        is_sending[c] = 1'b1;
        n_tx_byte     = n_tx_byte + 1;
        // drained and no longer filling: promote next
        if (!(in_frame && fill_s == c) && rd_pos[c] == fill_len[c]) begin
          if (is_done[c]) n_tx_frame = n_tx_frame + 1;
          t     = cur_s;
          cur_s = nxt_s;
          nxt_s = t;
          wipe_slot(nxt_s);
        end
      end
    end
    o.empty_res        = (rd_pos[cur_s] == fill_len[cur_s]);
    o.rx_byte_count    = n_rx_byte;
    o.tx_byte_count    = n_tx_byte;
    o.rx_frame_count   = n_rx_frame;
    o.tx_frame_count   = n_tx_frame;
    o.superseded_count = n_superseded;
    o.sync_error_count = n_sync_err;
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Cycle limit
  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: stall patterns, plus a long hold-off on request
  always @(posedge clk) begin
    rcv_cyc++;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left--;
    end else if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left  = HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rcv_mode  = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (rcv_mode)
        RX_OPEN:  rsp_ch.ready <= 1'b1;
        RX_LIGHT: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default:  rsp_ch.ready <= ((rcv_cyc % 5) != 0);
      endcase
    end
  end

  // Status checker: each word taken against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (status_due.size() == 0) begin
        $error("status word with none pending: %p", rsp_ch.data);
        fail_cnt++;
      end else begin
        due_w = status_due.pop_front();
        check_field("accepted", 32'(due_w.accepted), 32'(rsp_ch.data.accepted));
        check_field("tx_byte", 32'(due_w.tx_byte), 32'(rsp_ch.data.tx_byte));
        check_field("empty_res", 32'(due_w.empty_res), 32'(rsp_ch.data.empty_res));
        check_field("rx_byte_count", due_w.rx_byte_count, rsp_ch.data.rx_byte_count);
        check_field("tx_byte_count", due_w.tx_byte_count, rsp_ch.data.tx_byte_count);
        check_field("rx_frame_count", due_w.rx_frame_count, rsp_ch.data.rx_frame_count);
        check_field("tx_frame_count", due_w.tx_frame_count, rsp_ch.data.tx_frame_count);
        check_field("superseded_count", due_w.superseded_count,
                    rsp_ch.data.superseded_count);
        check_field("sync_error_count", due_w.sync_error_count,
                    rsp_ch.data.sync_error_count);
      end
    end
  end

  // Offer one request word; bursts with random gaps unless gaps are off
  task automatic send_word(logic kind, logic [7:0] b);
    in_word_t  w;
    out_word_t st;
    w.kind    = kind;
    w.rx_byte = b;
    if (!no_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        cmd_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= w;
    do @(posedge clk); while (!cmd_ch.ready);
    st = predict_status(w);
    status_due.push_back(st);
    if (st.accepted) moved_cnt++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write: setup then access; back-to-back transfers keep psel high
  task automatic apb_write(reg_idx_t idx, logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_HEADER:      fmt.header_byte  = v;
      REG_FOOTER_MASK: fmt.footer_mask  = v;
      default:         fmt.footer_value = v;
    endcase
  endtask

  task automatic apb_read_check(reg_idx_t idx, logic [7:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PADDR_W'(int'(idx) * 4);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(want)) begin
      $error("%s: expected %0h, actual %0h", idx.name(), want, prdata);
      fail_cnt++;
    end
  endtask

  task automatic apb_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Program the frame format and read it back; pipe must be idle
  task automatic set_format(logic [7:0] h, logic [7:0] m, logic [7:0] v);
    apb_write(REG_HEADER, h);
    apb_write(REG_FOOTER_MASK, m);
    apb_write(REG_FOOTER_VALUE, v);
    apb_read_check(REG_HEADER, h);
    apb_read_check(REG_FOOTER_MASK, m);
    apb_read_check(REG_FOOTER_VALUE, v);
    apb_idle();
  endtask

  // Last frame byte: footer match if good, else one masked bit off (if any set)
  function automatic logic [7:0] footer_for(logic good);
    logic [7:0] f;
    int         k;
    f = (fmt.footer_value & fmt.footer_mask) | (8'($urandom) & ~fmt.footer_mask);
    if (!good && fmt.footer_mask != 8'h00) begin
      do k = $urandom_range(0, 7); while (!fmt.footer_mask[k]);
      f[k] = ~f[k];
    end
    return f;
  endfunction

  // Header plus len-1 bytes; len == FL ends on a footer. Pops mixed in.
  task automatic push_frame(logic good, int pop_pct, int len);
    send_word(KIND_PUSH, fmt.header_byte);
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(0, 99) < pop_pct) send_word(KIND_POP, 8'($urandom));
      if (i == FL - 1) send_word(KIND_PUSH, footer_for(good));
      else send_word(KIND_PUSH, 8'($urandom));
    end
  endtask

  task automatic pop_burst(int n);
    repeat (n) send_word(KIND_POP, 8'($urandom));
  endtask

  // ---- tests ----

  task automatic test_reset_values();
    apb_read_check(REG_HEADER, HEADER_RST);
    apb_read_check(REG_FOOTER_MASK, FOOTER_MASK_RST);
    apb_read_check(REG_FOOTER_VALUE, FOOTER_VALUE_RST);
    apb_idle();
  endtask

  // pops with nothing unread, bytes outside a frame
  task automatic test_refused_and_empty();
    send_word(KIND_POP, 8'hFF);
    send_word(KIND_PUSH, 8'h00);
    send_word(KIND_PUSH, 8'hFF);
    send_word(KIND_PUSH, fmt.header_byte ^ 8'h01);
    send_word(KIND_POP, 8'h00);
    wait_idle();
  endtask

  // frame popped while it arrives; data holds 00, FF and the header value
  task automatic test_streamed_frame();
    logic [7:0] b;
    send_word(KIND_PUSH, fmt.header_byte);
    send_word(KIND_POP, 8'hA5);
    for (int i = 1; i < FL; i++) begin
      if (i == 1) b = 8'h00;
      else if (i == 2) b = 8'hFF;
      else if (i == 3) b = fmt.header_byte;
      else if (i == FL - 1) b = footer_for(1'b1);
      else b = 8'($urandom);
      send_word(KIND_PUSH, b);
      send_word(KIND_POP, 8'($urandom));
    end
    send_word(KIND_POP, 8'h5A);
    wait_idle();
  endtask

  // bad footer in the current slot: bytes stay readable
  task automatic test_bad_footer_current();
    push_frame(1'b0, 0, FL);
    pop_burst(FL + 1);
    wait_idle();
  endtask

  // frames stacked up with no pops: current, next, superseding spare, bad spare, superseding spare
  task automatic test_queued_frames();
    push_frame(1'b1, 0, FL);
    push_frame(1'b1, 0, FL);
    push_frame(1'b1, 0, FL);
    push_frame(1'b0, 0, FL);
    push_frame(1'b1, 0, FL);
    pop_burst(2 * FL + 2);
    wait_idle();
  endtask

  // receiver holds off long while the sender keeps offering
  task automatic test_stalled_output();
    no_gaps = 1'b1;
    hold_asked++;
    push_frame(1'b1, 40, FL);
    pop_burst(10);
    no_gaps = 1'b0;
    wait_idle();
  endtask

  task automatic random_segment();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) push_frame(1'b1, $urandom_range(0, 60), FL);
    else if (r < 67) push_frame(1'b0, $urandom_range(0, 60), FL);
    else if (r < 75) push_frame(1'b1, $urandom_range(0, 50), $urandom_range(1, FL - 1));
    else if (r < 90) pop_burst($urandom_range(1, 2 * FL));
    else repeat ($urandom_range(1, 5)) send_word(KIND_PUSH, 8'($urandom));
  endtask

  task automatic run_phase(logic [7:0] h, logic [7:0] m, logic [7:0] v, int target);
    int start;
    set_format(h, m, v);
    start = moved_cnt;
    while (moved_cnt - start < target) random_segment();
    pop_burst(2 * FL);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [7:0] m;
    run_phase(8'h00, 8'h00, 8'h00, 290);
    run_phase(8'hFF, 8'hFF, 8'hFF, 290);
    m = 8'($urandom);
    run_phase(8'($urandom), m, 8'($urandom) & m, 290);
    // footer value outside the mask: every frame ends in a sync error
    run_phase(8'($urandom), 8'h0F, 8'hF0, 170);
    run_phase(HEADER_RST, FOOTER_MASK_RST, FOOTER_VALUE_RST, 290);
  endtask

  // Sequence
  initial begin
    rst          = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    init_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_refused_and_empty();
    test_streamed_frame();
    test_bad_footer_current();
    test_queued_frames();
    test_stalled_output();
    test_random_traffic();

    wait_idle();
    repeat (5) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
